[hw/rtl/swsc_pkg.sv]
package swsc_pkg;

   // field and register widths fixed by the interface
   localparam int COUNT_W    = 32;
   localparam int WIN_LEN_W  = 11;
   localparam int SPREAD_W   = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPREAD = 2'd1;

   // reset values of the registers
   localparam logic [WIN_LEN_W-1:0] WINDOW_LEN_RST = 11'd1;
   localparam logic [SPREAD_W-1:0]  MAX_SPREAD_RST = 16'd0;

   // controller to datapath
   typedef struct packed {
      logic load;        // write the accepted sample, advance the counters
      logic scan_start;  // set up a scan of the current window
      logic scan;        // step the scan by one stored sample
      logic emit;        // load the result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;        // enough samples seen for the current window
      logic scan_done;   // every sample of the window folded into max and min
      logic qualify;     // max minus min within the allowed spread
   } status_type;

endpackage

[hw/rtl/sliding_window_spread_check.sv]
// flow: after acceptance the fill level is evaluated, the window (window_len clipped to
// 1..MAX_WINDOW) scanned and the spread checked; the result register is loaded only once
// an earlier result is no longer held by rsp_stall; req_stall holds off the next sample until
// idle again, the window being scanned one sample per cycle by the single read port of the store
// reset: synchronous, active high; clears counters, the write pointer, handshake state and registers
// to window_len = 1 and max_spread = 0; the sample store needs no clearing pass
module sliding_window_spread_check #(
   parameter int MAX_WINDOW  = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // sample transactions
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [SAMPLE_BITS-1:0]               req_sample,
   // result transactions
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [swsc_pkg::COUNT_W-1:0]         rsp_window_start,
   // register writes
   input  logic                                 csr_we,
   input  logic [swsc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [swsc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic [swsc_pkg::WIN_LEN_W-1:0] window_len_ff, window_len_in;
   logic [swsc_pkg::SPREAD_W-1:0]  max_spread_ff, max_spread_in;
   swsc_pkg::cmd_type              cmd;
   swsc_pkg::status_type           status;

   // register file: writes to unknown indexes fall through untouched
   always_comb begin
      window_len_in = window_len_ff;
      max_spread_in = max_spread_ff;
      if (csr_we) begin
         case (csr_index)
            swsc_pkg::CSR_WINDOW_LEN: window_len_in = csr_wdata[swsc_pkg::WIN_LEN_W-1:0];
            swsc_pkg::CSR_MAX_SPREAD: max_spread_in = csr_wdata[swsc_pkg::SPREAD_W-1:0];
            default: begin
               window_len_in = window_len_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= swsc_pkg::WINDOW_LEN_RST;
         max_spread_ff <= swsc_pkg::MAX_SPREAD_RST;
      end else begin
         window_len_ff <= window_len_in;
         max_spread_ff <= max_spread_in;
      end
   end

   // sequencer: accept, evaluate fill level, scan the window, check spread, emit
   swsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // sample store, position counter, max and min trackers and result register
   swsc_dpath #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .sample       (req_sample),
      .window_len   (window_len_ff),
      .max_spread   (max_spread_ff),
      .window_start (rsp_window_start)
   );

endmodule

[hw/rtl/swsc_ctrl.sv]
module swsc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output swsc_pkg::cmd_type    cmd,
   input  swsc_pkg::status_type status
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EVAL  = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_CHECK = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.load       = req_valid && (state_ff == S_IDLE);
      cmd.scan       = (state_ff == S_SCAN);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EVAL;
         end
         S_EVAL: begin
            if (status.full) begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (status.scan_done) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!status.qualify) begin
               state_in = S_IDLE;
            end else if (slot_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_EVAL)
      else $error("accepted transaction did not move to evaluation");

   a_qualify_emits: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CHECK && status.qualify && slot_free |=> rsp_valid_ff)
      else $error("qualifying window gave no result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff)
      else $error("waiting result lost");

endmodule

[hw/rtl/swsc_dpath.sv]
module swsc_dpath #(
   parameter int MAX_WINDOW  = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  swsc_pkg::cmd_type                     cmd,
   output swsc_pkg::status_type                  status,
   input  logic [SAMPLE_BITS-1:0]                sample,
   input  logic [swsc_pkg::WIN_LEN_W-1:0]        window_len,
   input  logic [swsc_pkg::SPREAD_W-1:0]         max_spread,
   output logic [swsc_pkg::COUNT_W-1:0]          window_start
);

   localparam int AW    = $clog2(MAX_WINDOW);
   localparam int LEN_W = $clog2(MAX_WINDOW + 1);
   localparam int EW    = (LEN_W > swsc_pkg::WIN_LEN_W) ? LEN_W : swsc_pkg::WIN_LEN_W;
   localparam int CW    = (SAMPLE_BITS > swsc_pkg::SPREAD_W) ? SAMPLE_BITS : swsc_pkg::SPREAD_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WINDOW - 1);
   localparam logic [EW-1:0] MAX_LEN   = EW'(MAX_WINDOW);

   logic [SAMPLE_BITS-1:0]       store_ff [MAX_WINDOW];
   logic [SAMPLE_BITS-1:0]       rd_data_ff;
   logic [AW-1:0]                wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]                rd_ptr_ff, rd_ptr_in;
   logic [swsc_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                         sat_ff, sat_in;
   logic [LEN_W-1:0]             left_ff, left_in;
   logic                         pend_ff, pend_in;
   logic [SAMPLE_BITS-1:0]       hi_ff, hi_in;
   logic [SAMPLE_BITS-1:0]       lo_ff, lo_in;
   logic [swsc_pkg::COUNT_W-1:0] start_ff;
   logic [EW-1:0]                len_ext;
   logic [LEN_W-1:0]             len_eff;
   logic [SAMPLE_BITS-1:0]       spread;
   logic [swsc_pkg::COUNT_W-1:0] start_calc;

   // zero length reads as one, too long a window is clipped
   always_comb begin
      len_ext = EW'(window_len);
      if (len_ext == '0) begin
         len_ext = EW'(1);
      end else if (len_ext > MAX_LEN) begin
         len_ext = MAX_LEN;
      end
      len_eff = LEN_W'(len_ext);
   end

   assign status.full      = (swsc_pkg::COUNT_W'(len_eff) <= count_ff);
   assign status.scan_done = (left_ff == '0) && !pend_ff;
   assign spread           = hi_ff - lo_ff;
   assign status.qualify   = (CW'(spread) <= CW'(max_spread));

   assign start_calc = sat_ff ? '1
                      : count_ff - swsc_pkg::COUNT_W'(len_eff) + swsc_pkg::COUNT_W'(1);
   assign window_start = start_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      sat_in    = sat_ff;
      rd_ptr_in = rd_ptr_ff;
      left_in   = left_ff;
      pend_in   = 1'b0;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      if (cmd.load) begin
         wr_ptr_in = (wr_ptr_ff == LAST_ADDR) ? '0 : wr_ptr_ff + AW'(1);
         sat_in    = (count_ff == '1);
         if (count_ff != '1) count_in = count_ff + swsc_pkg::COUNT_W'(1);
      end
      if (cmd.scan_start) begin
         rd_ptr_in = (wr_ptr_ff == '0) ? LAST_ADDR : wr_ptr_ff - AW'(1);
         left_in   = len_eff;
         hi_in     = '0;
         lo_in     = '1;
      end else begin
         if (cmd.scan && (left_ff != '0)) begin
            rd_ptr_in = (rd_ptr_ff == '0) ? LAST_ADDR : rd_ptr_ff - AW'(1);
            left_in   = left_ff - LEN_W'(1);
            pend_in   = 1'b1;
         end
         if (pend_ff) begin
            if (rd_data_ff > hi_ff) hi_in = rd_data_ff;
            if (rd_data_ff < lo_ff) lo_in = rd_data_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) store_ff[wr_ptr_ff] <= sample;
      rd_data_ff <= store_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         count_ff  <= '0;
         sat_ff    <= 1'b0;
         left_ff   <= '0;
         pend_ff   <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
         sat_ff    <= sat_in;
         left_ff   <= left_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      if (cmd.emit) start_ff <= start_calc;
   end

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> count_ff >= $past(count_ff))
      else $error("sample count went backwards");

   a_fold_order: assert property (@(posedge clock) disable iff (reset)
      pend_ff && !cmd.scan_start |=> lo_ff <= hi_ff)
      else $error("minimum above maximum after folding a sample");

endmodule
